FILE: rtl/uer_pkg.sv
package uer_pkg;

  localparam int TICK_W     = 16;
  localparam int UD_W       = 8;
  localparam int WL_W       = 5;
  localparam int D_W        = 15;
  localparam int SUM_W      = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int MAX_WINDOW_DEF = 16;

  localparam logic [TICK_W-1:0] LOW_TICKS  = TICK_W'(2);
  localparam logic [TICK_W-1:0] HIGH_TICKS = TICK_W'(10);

  localparam logic [TICK_W-1:0] TIMEOUT_RST  = TICK_W'(20000);
  localparam logic [UD_W-1:0]   UNIT_DIV_RST = UD_W'(28);
  localparam logic [WL_W-1:0]   WINDOW_RST   = WL_W'(1);
  localparam logic              SHARED_RST   = 1'b0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIMEOUT  = 2'd0,
    CFG_UNIT_DIV = 2'd1,
    CFG_WINDOW   = 2'd2,
    CFG_SHARED   = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_LOW  = 3'd1,
    PH_HIGH = 3'd2,
    PH_WAIT = 3'd3,
    PH_MEAS = 3'd4
  } ph_e;

  typedef enum logic [1:0] {
    SEQ_IDLE = 2'd0,
    SEQ_DIST = 2'd1,
    SEQ_AVG  = 2'd2
  } seq_e;

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic done;
  } div_sts_t;

endpackage

FILE: rtl/uer_if.sv
interface uer_in_if import uer_pkg::*; ();
  logic valid;
  logic ready;
  logic start_req;
  logic echo_level;

  modport source (output valid, output start_req, output echo_level, input ready);
  modport sink   (input valid, input start_req, input echo_level, output ready);
endinterface

interface uer_out_if import uer_pkg::*; ();
  logic           valid;
  logic           ready;
  logic           trigger_level;
  logic           trigger_drive;
  logic           busy_res;
  logic           done_res;
  logic [D_W-1:0] distance;
  logic [D_W-1:0] average;
  logic           echo_seen;

  modport source (
    output valid, output trigger_level, output trigger_drive, output busy_res,
    output done_res, output distance, output average, output echo_seen,
    input ready
  );
  modport sink (
    input valid, input trigger_level, input trigger_drive, input busy_res,
    input done_res, input distance, input average, input echo_seen,
    output ready
  );
endinterface

interface uer_cfg_if import uer_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/uer_div.sv
module uer_div import uer_pkg::*; #(
  parameter int DIVIDEND_W = SUM_W,
  parameter int DIVISOR_W  = UD_W
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  div_ctl_t              ctl_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output div_sts_t              sts_o,
  output logic [DIVIDEND_W-1:0] quotient_o
);

  localparam int CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIVIDEND_W - 1);

  logic                  active_q, done_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [DIVIDEND_W-1:0] quo_q;
  logic [DIVISOR_W-1:0]  rem_q, dvs_q;
  logic [DIVISOR_W-1:0]  rem_d;
  logic [DIVISOR_W:0]    trial;
  logic                  qbit;

  // one restoring step per cycle, msb first
  always_comb begin
    trial = {rem_q, quo_q[DIVIDEND_W-1]};
    if (trial >= {1'b0, dvs_q}) begin
      qbit  = 1'b1;
      rem_d = DIVISOR_W'(trial - {1'b0, dvs_q});
    end else begin
      qbit  = 1'b0;
      rem_d = trial[DIVISOR_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        active_q <= 1'b1;
        cnt_q    <= '0;
      end else if (active_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_LAST) begin
          active_q <= 1'b0;
          done_q   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (active_q) begin
      quo_q <= {quo_q[DIVIDEND_W-2:0], qbit};
      rem_q <= rem_d;
    end
  end

  assign sts_o.done = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: rtl/ultrasonic_echo_ranger_avg.sv
// Ultrasonic echo ranger with moving average. Each accepted request is one
// microsecond tick carrying start_req and echo_level, and gives exactly one
// result with the trigger levels, status flags and the latest distance and
// average. A tick that ends no measurement has its result registered, and it
// sits in the output register while the next request is taken. The tick
// that ends a measurement runs a shared restoring divider, one quotient bit
// per cycle: once for width / unit_divisor, and once more for sum / window
// when window_length is above one; no new request is taken until its result
// appears. The distance history is held in flip-flops cleared by reset, so
// no clearing pass is needed.
module ultrasonic_echo_ranger_avg import uer_pkg::*; #(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  uer_in_if.sink    in_i,
  uer_out_if.source out_o,
  uer_cfg_if.sink   cfg_i
);

  localparam int NW = $clog2(MAX_WINDOW + 1);
  localparam int IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CW = (NW > WL_W) ? NW : WL_W;
  localparam int DW = (NW > UD_W) ? NW : UD_W;

  // configuration
  logic [TICK_W-1:0] timeout_q;
  logic [UD_W-1:0]   unit_div_q;
  logic [WL_W-1:0]   window_q;
  logic              shared_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q  <= TIMEOUT_RST;
      unit_div_q <= UNIT_DIV_RST;
      window_q   <= WINDOW_RST;
      shared_q   <= SHARED_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_TIMEOUT:  timeout_q  <= cfg_i.data[TICK_W-1:0];
        CFG_UNIT_DIV: unit_div_q <= cfg_i.data[UD_W-1:0];
        CFG_WINDOW:   window_q   <= cfg_i.data[WL_W-1:0];
        CFG_SHARED:   shared_q   <= cfg_i.data[0];
      endcase
    end
  end

  // effective window and divisor
  logic [NW-1:0]   win_n;
  logic [CW-1:0]   win_ext;
  logic [UD_W-1:0] ud_eff;

  always_comb begin
    win_ext = CW'(window_q);
    if (win_ext == '0) begin
      win_n = NW'(1);
    end else if (win_ext > CW'(MAX_WINDOW)) begin
      win_n = NW'(MAX_WINDOW);
    end else begin
      win_n = NW'(win_ext);
    end
    ud_eff = (unit_div_q == '0) ? UD_W'(1) : unit_div_q;
  end

  // tick state machine
  ph_e               phase_q, phase_d;
  logic [TICK_W-1:0] tick_q, tick_d, tick_inc;
  logic              fin;
  logic [TICK_W-1:0] width;
  logic              lvl, drv, bsy;
  logic              accept;

  assign tick_inc = tick_q + TICK_W'(1);

  always_comb begin
    phase_d = phase_q;
    tick_d  = tick_q;
    fin     = 1'b0;
    width   = '0;
    unique case (phase_q)
      PH_IDLE: begin
        if (in_i.start_req) begin
          phase_d = PH_LOW;
          tick_d  = TICK_W'(1);
        end
      end
      PH_LOW: begin
        if (tick_q >= LOW_TICKS) begin
          phase_d = PH_HIGH;
          tick_d  = TICK_W'(1);
        end else begin
          tick_d = tick_inc;
        end
      end
      PH_HIGH: begin
        if (tick_q >= HIGH_TICKS) begin
          phase_d = PH_WAIT;
          tick_d  = '0;
        end else begin
          tick_d = tick_inc;
        end
      end
      PH_WAIT: begin
        if (in_i.echo_level) begin
          phase_d = PH_MEAS;
          tick_d  = TICK_W'(1);
          if (TICK_W'(1) >= timeout_q) begin
            fin   = 1'b1;
            width = TICK_W'(1);
          end
        end else begin
          tick_d = tick_inc;
          if (tick_inc >= timeout_q) begin
            fin = 1'b1;
          end
        end
      end
      PH_MEAS: begin
        if (in_i.echo_level) begin
          tick_d = tick_inc;
          if (tick_inc >= timeout_q) begin
            fin   = 1'b1;
            width = tick_inc;
          end
        end else begin
          fin   = 1'b1;
          width = tick_q;
        end
      end
      default: begin
        phase_d = PH_IDLE;
        tick_d  = '0;
      end
    endcase
    if (fin) begin
      phase_d = PH_IDLE;
      tick_d  = '0;
    end
  end

  always_comb begin
    lvl = 1'b0;
    drv = !shared_q;
    bsy = 1'b1;
    unique case (phase_q)
      PH_IDLE: begin
        if (in_i.start_req) begin
          drv = 1'b1;
        end else begin
          bsy = 1'b0;
        end
      end
      PH_LOW: begin
        drv = 1'b1;
        lvl = (tick_q >= LOW_TICKS);
      end
      PH_HIGH: begin
        drv = 1'b1;
        lvl = !(tick_q >= HIGH_TICKS);
      end
      PH_WAIT, PH_MEAS: begin
        lvl = 1'b0;
      end
      default: begin
        bsy = 1'b0;
      end
    endcase
  end

  // sequencer around the shared divider
  seq_e seq_q, seq_d;
  logic out_valid_q, out_valid_d;

  div_ctl_t          div_ctl;
  div_sts_t          div_sts;
  logic [SUM_W-1:0]  div_dividend;
  logic [DW-1:0]     div_divisor;
  logic [SUM_W-1:0]  quotient;

  logic [D_W-1:0]   hist_q [MAX_WINDOW];
  logic [D_W-1:0]   hist_rd;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [D_W-1:0]   dist_q, avg_q, dist_new;
  logic             dist_step, avg_step;

  assign in_i.ready = (seq_q == SEQ_IDLE) && (!out_valid_q || out_o.ready);
  assign accept     = in_i.valid && in_i.ready;

  assign dist_new = quotient[D_W:1];
  assign hist_rd  = hist_q[IW'(win_n - NW'(1))];
  assign sum_d    = sum_q + SUM_W'(dist_new) - SUM_W'(hist_rd);

  always_comb begin
    seq_d = seq_q;
    unique case (seq_q)
      SEQ_IDLE: if (accept && fin) seq_d = SEQ_DIST;
      SEQ_DIST: begin
        if (div_sts.done) begin
          seq_d = (win_n == NW'(1)) ? SEQ_IDLE : SEQ_AVG;
        end
      end
      SEQ_AVG: if (div_sts.done) seq_d = SEQ_IDLE;
      default: seq_d = SEQ_IDLE;
    endcase
  end

  always_comb begin
    dist_step     = (seq_q == SEQ_DIST) && div_sts.done;
    avg_step      = (seq_q == SEQ_AVG) && div_sts.done;
    div_ctl.start = (accept && fin) || (dist_step && (win_n != NW'(1)));
    if (seq_q == SEQ_IDLE) begin
      div_dividend = SUM_W'(width);
      div_divisor  = DW'(ud_eff);
    end else begin
      div_dividend = sum_d;
      div_divisor  = DW'(win_n);
    end
    if (accept) begin
      out_valid_d = !fin;
    end else if ((dist_step && (win_n == NW'(1))) || avg_step) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  uer_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (DW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (div_ctl),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .sts_o      (div_sts),
    .quotient_o (quotient)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      tick_q      <= '0;
      seq_q       <= SEQ_IDLE;
      out_valid_q <= 1'b0;
      sum_q       <= '0;
      dist_q      <= '0;
      avg_q       <= '0;
      for (int i = 0; i < MAX_WINDOW; i++) begin
        hist_q[i] <= '0;
      end
    end else begin
      seq_q       <= seq_d;
      out_valid_q <= out_valid_d;
      if (accept) begin
        phase_q <= phase_d;
        tick_q  <= tick_d;
      end
      if (dist_step) begin
        sum_q  <= sum_d;
        dist_q <= dist_new;
        if (win_n == NW'(1)) begin
          avg_q <= dist_new;
        end
        for (int i = 0; i < MAX_WINDOW; i++) begin
          if (NW'(i) < win_n) begin
            hist_q[i] <= (i == 0) ? dist_new : hist_q[(i == 0) ? 0 : i - 1];
          end
        end
      end
      if (avg_step) begin
        avg_q <= quotient[D_W-1:0];
      end
    end
  end

  // tick flags of the pending result
  logic lvl_q, drv_q, bsy_q, done_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      lvl_q  <= lvl;
      drv_q  <= drv;
      bsy_q  <= bsy;
      done_q <= fin;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.trigger_level = lvl_q;
  assign out_o.trigger_drive = drv_q;
  assign out_o.busy_res      = bsy_q;
  assign out_o.done_res      = done_q;
  assign out_o.distance      = dist_q;
  assign out_o.average       = avg_q;
  assign out_o.echo_seen     = (dist_q != '0);

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top import uer_pkg::*; ();

  localparam int CFG_SETTLE = 48;
  localparam int END_SETTLE = 60;
  localparam int PHASE_TICKS = 100;

  typedef struct packed {
    logic           trig_level;
    logic           trig_drive;
    logic           busy;
    logic           done;
    logic [D_W-1:0] distance;
    logic [D_W-1:0] average;
    logic           seen;
  } tick_res_t;

  typedef struct {
    bit        start;
    bit        echo;
    bit        typed;
    tick_res_t res;
  } dir_row_t;

  typedef struct {
    logic [TICK_W-1:0] tmo;
    logic [UD_W-1:0]   udiv;
    logic [WL_W-1:0]   win;
    logic              shared;
  } reg_set_t;

  localparam tick_res_t RES_IDLE = '{trig_level: 1'b0, trig_drive: 1'b1, busy: 1'b0,
                                     done: 1'b0, distance: '0, average: '0, seen: 1'b0};
  localparam tick_res_t RES_START = '{trig_level: 1'b0, trig_drive: 1'b1, busy: 1'b1,
                                      done: 1'b0, distance: '0, average: '0, seen: 1'b0};
  localparam tick_res_t RES_DONE_ZERO = '{trig_level: 1'b0, trig_drive: 1'b1, busy: 1'b1,
                                          done: 1'b1, distance: '0, average: '0, seen: 1'b0};

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  uer_in_if  in_if ();
  uer_out_if out_if ();
  uer_cfg_if cfg_if ();

  ultrasonic_echo_ranger_avg DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  always #5 clk = ~clk;

  // ranger state mirror
  ph_e               rng_ph;
  logic [TICK_W-1:0] rng_cnt;
  logic [D_W-1:0]    dist_hist [0:MAX_WINDOW_DEF];
  logic [SUM_W-1:0]  dist_sum;
  logic [D_W-1:0]    last_dist;
  logic [D_W-1:0]    last_avg;

  logic [TICK_W-1:0] cfg_tmo;
  logic [UD_W-1:0]   cfg_udiv;
  logic [WL_W-1:0]   cfg_win;
  logic              cfg_shared;

  tick_res_t pending_ticks [$];
  int        mismatch_cnt = 0;
  int        ticks_sent = 0;
  int        src_idle_pct = 22;
  int        snk_idle_pct = 76;

  dir_row_t dir_rows [19] = '{
    '{1'b0, 1'b1, 1'b1, RES_IDLE},
    '{1'b1, 1'b0, 1'b1, RES_START},
    '{1'b1, 1'b1, 1'b0, '0},
    '{1'b0, 1'b1, 1'b0, '0},
    '{1'b1, 1'b0, 1'b0, '0},
    '{1'b0, 1'b0, 1'b0, '0},
    '{1'b1, 1'b1, 1'b0, '0},
    '{1'b0, 1'b1, 1'b0, '0},
    '{1'b1, 1'b0, 1'b0, '0},
    '{1'b0, 1'b0, 1'b0, '0},
    '{1'b1, 1'b1, 1'b0, '0},
    '{1'b0, 1'b1, 1'b0, '0},
    '{1'b1, 1'b0, 1'b0, '0},
    '{1'b0, 1'b0, 1'b0, '0},
    '{1'b0, 1'b0, 1'b0, '0},
    '{1'b1, 1'b1, 1'b0, '0},
    '{1'b0, 1'b1, 1'b0, '0},
    '{1'b0, 1'b0, 1'b1, RES_DONE_ZERO},
    '{1'b0, 1'b0, 1'b1, RES_IDLE}
  };

  reg_set_t reg_plan [7] = '{
    '{16'd40,    8'd1,   5'd0,  1'b1},
    '{16'd25,    8'd0,   5'd16, 1'b0},
    '{16'd60,    8'd255, 5'd31, 1'b1},
    '{16'd1,     8'd3,   5'd4,  1'b0},
    '{16'd0,     8'd7,   5'd3,  1'b1},
    '{16'd30,    8'd2,   5'd5,  1'b0},
    '{16'hFFFF,  8'd1,   5'd16, 1'b0}
  };

  function automatic void log_distance(logic [TICK_W-1:0] width);
    int unsigned div;
    int unsigned n;
    int unsigned d;
    int unsigned i;
    div = (cfg_udiv == '0) ? 1 : cfg_udiv;
    n = cfg_win;
    if (n == 0) n = 1;
    if (n > MAX_WINDOW_DEF) n = MAX_WINDOW_DEF;
    d = width / div / 2;
    dist_hist[0] = D_W'(d);
    dist_sum = SUM_W'(dist_sum + d - dist_hist[n]);
    for (i = n; i > 0; i--) dist_hist[i] = dist_hist[i-1];
    last_dist = D_W'(d);
    last_avg = (n == 1) ? D_W'(d) : D_W'(dist_sum / n);
    rng_ph = PH_IDLE;
    rng_cnt = '0;
  endfunction

  function automatic tick_res_t ranger_tick(bit start, bit echo);
    tick_res_t r;
    r = '0;
    r.trig_drive = ~cfg_shared;
    r.busy = 1'b1;
    case (rng_ph)
      PH_IDLE: begin
        if (start) begin
          rng_ph = PH_LOW;
          rng_cnt = TICK_W'(1);
          r.trig_drive = 1'b1;
        end else begin
          r.busy = 1'b0;
        end
      end
      PH_LOW: begin
        r.trig_drive = 1'b1;
        if (rng_cnt >= LOW_TICKS) begin
          rng_ph = PH_HIGH;
          rng_cnt = TICK_W'(1);
          r.trig_level = 1'b1;
        end else begin
          rng_cnt++;
        end
      end
      PH_HIGH: begin
        r.trig_drive = 1'b1;
        if (rng_cnt >= HIGH_TICKS) begin
          rng_ph = PH_WAIT;
          rng_cnt = '0;
        end else begin
          rng_cnt++;
          r.trig_level = 1'b1;
        end
      end
      PH_WAIT: begin
        if (echo) begin
          rng_ph = PH_MEAS;
          rng_cnt = TICK_W'(1);
          if (rng_cnt >= cfg_tmo) begin
            log_distance(rng_cnt);
            r.done = 1'b1;
          end
        end else begin
          rng_cnt++;
          if (rng_cnt >= cfg_tmo) begin
            log_distance('0);
            r.done = 1'b1;
          end
        end
      end
      PH_MEAS: begin
        if (echo) begin
          rng_cnt++;
          if (rng_cnt >= cfg_tmo) begin
            log_distance(rng_cnt);
            r.done = 1'b1;
          end
        end else begin
          log_distance(rng_cnt);
          r.done = 1'b1;
        end
      end
      default: begin
        rng_ph = PH_IDLE;
        rng_cnt = '0;
        r.busy = 1'b0;
      end
    endcase
    r.distance = last_dist;
    r.average = last_avg;
    r.seen = (last_dist != '0);
    return r;
  endfunction

  task automatic send_tick(input bit start, input bit echo, input bit typed = 1'b0,
                           input tick_res_t typed_res = '0);
    tick_res_t pred;
    if ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    in_if.valid      <= 1'b1;
    in_if.start_req  <= start;
    in_if.echo_level <= echo;
    do @(posedge clk); while (!in_if.ready);
    pred = ranger_tick(start, echo);
    pending_ticks.push_back(typed ? typed_res : pred);
    ticks_sent++;
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending_ticks.size() != 0);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      CFG_TIMEOUT:  cfg_tmo = val[TICK_W-1:0];
      CFG_UNIT_DIV: cfg_udiv = val[UD_W-1:0];
      CFG_WINDOW:   cfg_win = val[WL_W-1:0];
      CFG_SHARED:   cfg_shared = val[0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input reg_set_t s);
    wait_drained();
    repeat (CFG_SETTLE) @(posedge clk);
    write_reg(CFG_TIMEOUT, s.tmo);
    write_reg(CFG_UNIT_DIV, CFG_DATA_W'(s.udiv));
    write_reg(CFG_WINDOW, CFG_DATA_W'(s.win));
    write_reg(CFG_SHARED, CFG_DATA_W'(s.shared));
    cfg_if.valid <= 1'b0;
  endtask

  // one trigger and echo cycle, echo rises after gap waiting ticks and lasts width ticks
  task automatic measure(input int unsigned gap, input int unsigned width, input bit glitchy);
    bit e;
    send_tick(1'b1, 1'($urandom_range(1)));
    do begin
      case (rng_ph)
        PH_WAIT: e = (rng_cnt >= gap);
        PH_MEAS: e = (rng_cnt < width);
        default: e = 1'($urandom_range(1));
      endcase
      if (glitchy && (rng_ph == PH_WAIT || rng_ph == PH_MEAS) && $urandom_range(7) == 0)
        e = ~e;
      send_tick(1'($urandom_range(1)), e);
    end while (rng_ph != PH_IDLE);
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(3, 10))
      send_tick($urandom_range(3) == 0, 1'($urandom_range(1)));
    while (rng_ph != PH_IDLE)
      send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  always @(posedge clk) begin : result_check
    tick_res_t got;
    tick_res_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = '{out_if.trigger_level, out_if.trigger_drive, out_if.busy_res, out_if.done_res,
              out_if.distance, out_if.average, out_if.echo_seen};
      if (pending_ticks.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected tick result at %0t", $realtime);
      end else begin
        want = pending_ticks.pop_front();
        if (got !== want) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $write("tick result mismatch at %0t: ", $realtime);
            $write("exp trig %0b drv %0b busy %0b done %0b dist %0d avg %0d seen %0b, ",
                   want.trig_level, want.trig_drive, want.busy, want.done, want.distance,
                   want.average, want.seen);
            $display("got trig %0b drv %0b busy %0b done %0b dist %0d avg %0d seen %0b",
                     got.trig_level, got.trig_drive, got.busy, got.done, got.distance,
                     got.average, got.seen);
          end
        end
      end
    end
    out_if.ready <= rst_n && ($urandom_range(99) >= snk_idle_pct);
  end

  initial begin
    #20ms;
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    int phase_start;
    int hold_at;
    bit held;
    int unsigned gap;
    int unsigned width;
    int kind;
    in_if.valid      = 1'b0;
    in_if.start_req  = 1'b0;
    in_if.echo_level = 1'b0;
    out_if.ready     = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = CFG_TIMEOUT;
    cfg_if.data      = '0;
    cfg_tmo    = TIMEOUT_RST;
    cfg_udiv   = UNIT_DIV_RST;
    cfg_win    = WINDOW_RST;
    cfg_shared = SHARED_RST;
    rng_ph     = PH_IDLE;
    rng_cnt    = '0;
    dist_sum   = '0;
    last_dist  = '0;
    last_avg   = '0;
    foreach (dist_hist[i]) dist_hist[i] = '0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      send_tick(dir_rows[i].start, dir_rows[i].echo, dir_rows[i].typed, dir_rows[i].res);

    for (int p = 0; p < 6; p++) begin
      if (p == 2) begin
        src_idle_pct = 76;
        snk_idle_pct = 22;
      end else if (p == 4) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      program_regs(reg_plan[p]);
      phase_start = ticks_sent;
      hold_at = phase_start + $urandom_range(10, 100);
      held = 1'b0;
      while (ticks_sent - phase_start < PHASE_TICKS) begin
        if (!held && ticks_sent >= hold_at) begin
          wait_drained();
          held = 1'b1;
        end
        kind = $urandom_range(9);
        if (kind < 2) begin
          noise_burst();
        end else begin
          gap = ($urandom_range(7) == 0) ? cfg_tmo + 1 : $urandom_range(0, 4);
          width = ($urandom_range(7) == 0) ? cfg_tmo + 2 : $urandom_range(1, 24);
          measure(gap, width, kind < 4);
        end
        repeat ($urandom_range(0, 3)) send_tick(1'b0, 1'($urandom_range(1)));
      end
    end

    // longest timeout
    program_regs(reg_plan[6]);
    measure(2, 20, 1'b0);
    measure(0, 37, 1'b0);
    send_tick(1'b0, 1'b1);

    wait_drained();
    repeat (END_SETTLE) @(posedge clk);
    if (mismatch_cnt == 0 && pending_ticks.size() == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule
